// ----- hw/rtl/hidkbd_pkg.sv -----
// ----------------------------------------------------------------------------
// hidkbd_pkg
// Shared types, constants and helpers for the keyboard report to key event
// block.
// ----------------------------------------------------------------------------
package hidkbd_pkg;

  localparam int KEY_TABLE_SIZE  = 83;
  localparam int KEYS_PER_REPORT = 6;

  localparam int SLOT_FIELDS   = 6;
  localparam int SLOT_COUNT    = (KEYS_PER_REPORT < SLOT_FIELDS) ? KEYS_PER_REPORT
                                                                  : SLOT_FIELDS;
  localparam int CODE_W        = 8;
  localparam int KEY_CODE_W    = 7;
  localparam int MOD_BITS      = 8;
  localparam int SLOT_IDX_W    = 3;
  localparam int KEY_W         = $clog2(KEY_TABLE_SIZE);
  localparam int IDX_W         = KEY_W;
  localparam int FIRST_TRACKED = 4;
  localparam int EXCLUDED_CODE = 49;

  localparam logic [CODE_W-1:0] KEY_REPORT = 8'd2;

  // which datapath phase is active
  typedef enum logic [1:0] {
    PH_MOD  = 2'd0,
    PH_SLOT = 2'd1,
    PH_SCAN = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    IDX_HOLD = 2'd0,
    IDX_INC  = 2'd1,
    IDX_CLR  = 2'd2,
    IDX_SCAN = 2'd3
  } idx_op_t;

  typedef struct packed {
    logic    capture;
    logic    run;
    logic    flush;
    phase_t  phase;
    idx_op_t idx_op;
  } dp_cmd_t;

  typedef struct packed {
    logic can_step;
    logic mod_end;
    logic slot_end;
    logic scan_end;
  } dp_sts_t;

  typedef struct packed {
    logic                  is_modifier;
    logic [KEY_CODE_W-1:0] key_code;
    logic                  is_press;
    logic                  last;
  } evt_t;

  function automatic logic code_tracked(input logic [CODE_W-1:0] c);
    return (int'(c) >= FIRST_TRACKED) && (int'(c) < KEY_TABLE_SIZE) &&
           (int'(c) != EXCLUDED_CODE);
  endfunction

  function automatic logic [KEY_TABLE_SIZE-1:0] tracked_mask();
    logic [KEY_TABLE_SIZE-1:0] m;
    m = '0;
    for (int i = 0; i < KEY_TABLE_SIZE; i++) begin
      m[i] = code_tracked(CODE_W'(i));
    end
    return m;
  endfunction

  localparam logic [KEY_TABLE_SIZE-1:0] TRACKED_MASK = tracked_mask();

endpackage

// ----- hw/rtl/hidkbd_if.sv -----
// ----------------------------------------------------------------------------
// hidkbd interfaces
// Valid/ready channels for keyboard reports and key events.
// ----------------------------------------------------------------------------
interface hidkbd_rpt_if
  import hidkbd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] report_type;
  logic [CODE_W-1:0] modifier_bits;
  logic [CODE_W-1:0] key_slot_0;
  logic [CODE_W-1:0] key_slot_1;
  logic [CODE_W-1:0] key_slot_2;
  logic [CODE_W-1:0] key_slot_3;
  logic [CODE_W-1:0] key_slot_4;
  logic [CODE_W-1:0] key_slot_5;

  modport source (output valid, report_type, modifier_bits, key_slot_0, key_slot_1,
                  key_slot_2, key_slot_3, key_slot_4, key_slot_5, input ready);
  modport sink   (input valid, report_type, modifier_bits, key_slot_0, key_slot_1,
                  key_slot_2, key_slot_3, key_slot_4, key_slot_5, output ready);
endinterface

interface hidkbd_evt_if
  import hidkbd_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  is_modifier;
  logic [KEY_CODE_W-1:0] key_code;
  logic                  is_press;
  logic                  last;

  modport source (output valid, is_modifier, key_code, is_press, last, input ready);
  modport sink   (input valid, is_modifier, key_code, is_press, last, output ready);
endinterface

// ----- hw/rtl/hidkbd_ctrl.sv -----
// ----------------------------------------------------------------------------
// hidkbd_ctrl
// Sequencer: modifier pass, slot pass, held-map scan, then flush of the
// final event.
// ----------------------------------------------------------------------------
module hidkbd_ctrl
  import hidkbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [CODE_W-1:0] in_report_type,
  output logic              in_ready,
  input  dp_sts_t           sts,
  output dp_cmd_t           cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MOD   = 5'b00010,
    ST_SLOT  = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.phase = PH_MOD;
    cmd.idx_op = IDX_HOLD;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_report_type == KEY_REPORT)) begin
          cmd.capture = 1'b1;
          cmd.idx_op  = IDX_CLR;
          state_nxt   = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.phase = PH_MOD;
        if (sts.can_step) begin
          cmd.run    = 1'b1;
          cmd.idx_op = sts.mod_end ? IDX_CLR : IDX_INC;
          if (sts.mod_end) state_nxt = ST_SLOT;
        end
      end
      ST_SLOT: begin
        cmd.phase = PH_SLOT;
        if (sts.can_step) begin
          cmd.run    = 1'b1;
          cmd.idx_op = sts.slot_end ? IDX_SCAN : IDX_INC;
          if (sts.slot_end) state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.phase = PH_SCAN;
        if (sts.can_step) begin
          cmd.run    = 1'b1;
          cmd.idx_op = sts.scan_end ? IDX_HOLD : IDX_INC;
          if (sts.scan_end) state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd.phase = PH_SCAN;
        if (sts.can_step) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  a_flush_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) && sts.can_step |=> (state_r == ST_IDLE))
    else $error("flush did not return to idle");

  a_no_step_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !sts.can_step |-> !cmd.run && !cmd.flush)
    else $error("step issued while output register is blocked");
`endif

endmodule

// ----- hw/rtl/hidkbd_dp.sv -----
// ----------------------------------------------------------------------------
// hidkbd_dp
// Datapath: captured report, held state, index counter, one-word lookahead
// for the last flag, and the output register.
// ----------------------------------------------------------------------------
module hidkbd_dp
  import hidkbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  input  logic [CODE_W-1:0] in_modifier_bits,
  input  logic [CODE_W-1:0] in_key_slot_0,
  input  logic [CODE_W-1:0] in_key_slot_1,
  input  logic [CODE_W-1:0] in_key_slot_2,
  input  logic [CODE_W-1:0] in_key_slot_3,
  input  logic [CODE_W-1:0] in_key_slot_4,
  input  logic [CODE_W-1:0] in_key_slot_5,
  output logic              out_valid,
  input  logic              out_ready,
  output evt_t              out_evt
);

  logic [CODE_W-1:0]         mods_r;
  logic [CODE_W-1:0]         slots_r [SLOT_FIELDS];
  logic [MOD_BITS-1:0]       held_mod_r, held_mod_nxt;
  logic [KEY_TABLE_SIZE-1:0] held_r, held_nxt;
  logic [IDX_W-1:0]          idx_r;
  evt_t                      pend_evt_r, out_evt_r, new_evt;
  logic                      pend_valid_r, out_valid_r;
  logic                      gen;
  logic [SLOT_IDX_W-1:0]     si;
  logic [CODE_W-1:0]         slot_code;
  logic                      slot_trk, slot_held, present;

  assign si        = idx_r[SLOT_IDX_W-1:0];
  assign slot_code = (int'(si) < SLOT_FIELDS) ? slots_r[si] : '0;
  assign slot_trk  = code_tracked(slot_code);
  assign slot_held = slot_trk ? held_r[slot_code[KEY_W-1:0]] : 1'b0;

  always_comb begin
    present = 1'b0;
    for (int j = 0; j < SLOT_COUNT; j++) begin
      if (slots_r[j] == CODE_W'(idx_r)) present = 1'b1;
    end
  end

  always_comb begin
    gen          = 1'b0;
    new_evt      = '0;
    held_nxt     = held_r;
    held_mod_nxt = held_mod_r;
    case (cmd.phase)
      PH_MOD: begin
        gen                  = mods_r[si] ^ held_mod_r[si];
        new_evt.is_modifier  = 1'b1;
        new_evt.key_code     = KEY_CODE_W'(si);
        new_evt.is_press     = mods_r[si];
        held_mod_nxt[si]     = mods_r[si];
      end
      PH_SLOT: begin
        gen              = slot_trk && !slot_held;
        new_evt.key_code = slot_code[KEY_CODE_W-1:0];
        new_evt.is_press = 1'b1;
        if (slot_trk) held_nxt[slot_code[KEY_W-1:0]] = 1'b1;
      end
      PH_SCAN: begin
        gen              = held_r[idx_r] && !present;
        new_evt.key_code = KEY_CODE_W'(idx_r);
        if (gen) held_nxt[idx_r] = 1'b0;
      end
      default: gen = 1'b0;
    endcase
  end

  assign sts.can_step = !out_valid_r || out_ready;
  assign sts.mod_end  = (idx_r == IDX_W'(MOD_BITS - 1));
  assign sts.slot_end = (idx_r == IDX_W'(SLOT_COUNT - 1));
  assign sts.scan_end = (idx_r == IDX_W'(KEY_TABLE_SIZE - 1));

  // capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mods_r     <= in_modifier_bits;
      slots_r[0] <= in_key_slot_0;
      slots_r[1] <= in_key_slot_1;
      slots_r[2] <= in_key_slot_2;
      slots_r[3] <= in_key_slot_3;
      slots_r[4] <= in_key_slot_4;
      slots_r[5] <= in_key_slot_5;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.idx_op)
      IDX_INC:  idx_r <= idx_r + 1'b1;
      IDX_CLR:  idx_r <= '0;
      IDX_SCAN: idx_r <= IDX_W'(FIRST_TRACKED);
      default:  idx_r <= idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r     <= '0;
      held_mod_r <= '0;
    end else if (cmd.run) begin
      held_r     <= held_nxt;
      held_mod_r <= held_mod_nxt;
    end
  end

  // one word held back so the final event can carry last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.run && gen) begin
        pend_evt_r   <= new_evt;
        pend_valid_r <= 1'b1;
        out_valid_r  <= pend_valid_r || (out_valid_r && !out_ready);
        if (pend_valid_r) out_evt_r <= pend_evt_r;
      end else if (cmd.flush && pend_valid_r) begin
        out_evt_r    <= '{is_modifier: pend_evt_r.is_modifier,
                          key_code:    pend_evt_r.key_code,
                          is_press:    pend_evt_r.is_press,
                          last:        1'b1};
        out_valid_r  <= 1'b1;
        pend_valid_r <= 1'b0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_evt   = out_evt_r;

`ifndef SYNTH
  a_untracked_never_held: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r & ~TRACKED_MASK) == '0)
    else $error("untracked code marked held");

  a_flush_emits_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush && pend_valid_r |=> out_valid_r && out_evt_r.last && !pend_valid_r)
    else $error("flush did not deliver last word");

  a_last_only_on_flush: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.run && gen && pend_valid_r |=> out_valid_r && !out_evt_r.last)
    else $error("non-final word flagged last");
`endif

endmodule

// ----- hw/rtl/hid_keyboard_report_to_key_events_core.sv -----
// ----------------------------------------------------------------------------
// hid_keyboard_report_to_key_events_core
// Turns boot keyboard reports into modifier and key press/release events.
// ----------------------------------------------------------------------------
// Usage:
//   in_rpt  : one report word per handshake (type, modifier byte, six slots).
//   out_evt : one event word per handshake; last marks the final event of a
//             report. Reports of a type other than key report give no words.
//   A key report is taken when the sequencer is idle. It then steps over the
//   8 modifier bits, the SLOT_COUNT slots and held codes
//   FIRST_TRACKED..KEY_TABLE_SIZE-1, one entry per cycle while the output
//   register is not blocked, then flushes the final event. One word is held
//   back to learn whether it is the last: a word leaves when the next is found,
//   the final one at the flush.
//   A stalled receiver holds the output register and the sequencer waits
//   until the word is taken; nothing is dropped.
//   Reset (rst_n low, synchronous) clears held modifiers, the held-key map,
//   and all valid flags.
// ----------------------------------------------------------------------------
module hid_keyboard_report_to_key_events_core
  import hidkbd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  hidkbd_rpt_if.sink   in_rpt,
  hidkbd_evt_if.source out_evt
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  evt_t    evt;

  hidkbd_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_rpt.valid),
    .in_report_type (in_rpt.report_type),
    .in_ready       (in_rpt.ready),
    .sts            (sts),
    .cmd            (cmd)
  );

  hidkbd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_modifier_bits (in_rpt.modifier_bits),
    .in_key_slot_0    (in_rpt.key_slot_0),
    .in_key_slot_1    (in_rpt.key_slot_1),
    .in_key_slot_2    (in_rpt.key_slot_2),
    .in_key_slot_3    (in_rpt.key_slot_3),
    .in_key_slot_4    (in_rpt.key_slot_4),
    .in_key_slot_5    (in_rpt.key_slot_5),
    .out_valid        (out_evt.valid),
    .out_ready        (out_evt.ready),
    .out_evt          (evt)
  );

  assign out_evt.is_modifier = evt.is_modifier;
  assign out_evt.key_code    = evt.key_code;
  assign out_evt.is_press    = evt.is_press;
  assign out_evt.last        = evt.last;

endmodule

// ----- tb/sv/hid_keyboard_report_to_key_events_core_tb.sv -----
// ----------------------------------------------------------------------------
// hid_keyboard_report_to_key_events_core_tb
// Self-checking bench for the keyboard report to key event block. Reports go
// in on a valid/ready channel with random gaps. Each accepted report runs
// through a local model of the held modifier byte and held-key map, and the
// resulting event words are queued. Every event word taken from the output is
// compared field by field with the oldest queued word. The output side idles
// at random and once holds off for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
module hid_keyboard_report_to_key_events_core_tb
  import hidkbd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_KEY_REPORTS = 210;
  localparam int LONG_HOLD_CYCLES   = 600;
  localparam int DRAIN_LIMIT        = 20000;
  localparam int TAIL_CYCLES        = 150;
  localparam int MAX_PRINTS         = 60;

  typedef struct {
    logic [CODE_W-1:0] kind;
    logic [CODE_W-1:0] mods;
    logic [CODE_W-1:0] slot [SLOT_FIELDS];
  } report_word_t;

  // --------------------------------------------------------------------------
  // Key state model and queue of expected event words
  // --------------------------------------------------------------------------
  class key_event_sb;
    logic [MOD_BITS-1:0] held_mods;
    bit                  held_map [KEY_TABLE_SIZE];
    evt_t                expected_q [$];
    int                  mismatches;
    int                  events_checked;
    int                  reports_seen;
    int                  key_reports;

    function new();
      held_mods = '0;
      foreach (held_map[i]) held_map[i] = 1'b0;
      mismatches     = 0;
      events_checked = 0;
      reports_seen   = 0;
      key_reports    = 0;
    endfunction

    function bit is_tracked(logic [CODE_W-1:0] c);
      return (c >= FIRST_TRACKED) && (c < KEY_TABLE_SIZE) && (c != EXCLUDED_CODE);
    endfunction

    function void push_event(ref evt_t evs [$], input bit modi, int code, bit press);
      evt_t ev;
      ev.is_modifier = modi;
      ev.key_code    = KEY_CODE_W'(code);
      ev.is_press    = press;
      ev.last        = 1'b0;
      evs.push_back(ev);
    endfunction

    function void note_report(report_word_t r);
      evt_t evs [$];
      bit   present;
      reports_seen++;
      if (r.kind != KEY_REPORT) return;
      key_reports++;
      for (int i = 0; i < MOD_BITS; i++) begin
        if (r.mods[i] != held_mods[i]) push_event(evs, 1'b1, i, r.mods[i]);
      end
      held_mods = r.mods;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (is_tracked(r.slot[i]) && !held_map[r.slot[i]]) begin
          push_event(evs, 1'b0, r.slot[i], 1'b1);
          held_map[r.slot[i]] = 1'b1;
        end
      end
      // released keys come out in ascending code order
      for (int k = FIRST_TRACKED; k < KEY_TABLE_SIZE; k++) begin
        if (held_map[k]) begin
          present = 1'b0;
          for (int j = 0; j < SLOT_COUNT; j++) begin
            if (r.slot[j] == k) present = 1'b1;
          end
          if (!present) begin
            push_event(evs, 1'b0, k, 1'b0);
            held_map[k] = 1'b0;
          end
        end
      end
      if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
      foreach (evs[i]) expected_q.push_back(evs[i]);
    endfunction

    task report_mismatch(string what, int exp_v, int got_v);
      if (mismatches < MAX_PRINTS)
        $display("%0t ns mismatch on event %0d: %s expected %0d got %0d",
                 $time, events_checked, what, exp_v, got_v);
      mismatches++;
    endtask

    task check_event(evt_t got);
      evt_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word, queue depth", 0, 1);
        events_checked++;
        return;
      end
      want = expected_q.pop_front();
      if (got.is_modifier !== want.is_modifier)
        report_mismatch("is_modifier", want.is_modifier, got.is_modifier);
      if (got.key_code !== want.key_code)
        report_mismatch("key_code", want.key_code, got.key_code);
      if (got.is_press !== want.is_press)
        report_mismatch("is_press", want.is_press, got.is_press);
      if (got.last !== want.last)
        report_mismatch("last", want.last, got.last);
      events_checked++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;
  always #1 clk = ~clk;

  hidkbd_rpt_if rpt_if ();
  hidkbd_evt_if evt_if ();

  hid_keyboard_report_to_key_events_core DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_rpt  (rpt_if),
    .out_evt (evt_if)
  );

  key_event_sb sb = new();

  // written by the sender with NBAs, read by the receiver
  int unsigned hold_req = 0;
  bit          no_idle  = 1'b0;

  function automatic int unsigned sender_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(60, 20);
  endfunction

  function automatic int unsigned receiver_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic report_word_t mk(int kind, int mods, int s0, int s1, int s2,
                                      int s3, int s4, int s5);
    report_word_t r;
    r.kind    = CODE_W'(kind);
    r.mods    = CODE_W'(mods);
    r.slot[0] = CODE_W'(s0);
    r.slot[1] = CODE_W'(s1);
    r.slot[2] = CODE_W'(s2);
    r.slot[3] = CODE_W'(s3);
    r.slot[4] = CODE_W'(s4);
    r.slot[5] = CODE_W'(s5);
    return r;
  endfunction

  // Often carries keys over from the previous report so presses and
  // releases interleave; some slots get fresh, empty, duplicate or wild codes.
  function automatic report_word_t next_key_report(report_word_t prev);
    report_word_t r;
    int unsigned  p;
    r.kind = KEY_REPORT;
    if ($urandom_range(99) < 60) begin
      r.mods = prev.mods ^ (CODE_W'(1) << $urandom_range(7));
      if ($urandom_range(1)) r.mods = r.mods ^ (CODE_W'(1) << $urandom_range(7));
    end else begin
      r.mods = CODE_W'($urandom_range(255));
    end
    for (int i = 0; i < SLOT_FIELDS; i++) begin
      p = $urandom_range(99);
      if (p < 40)                r.slot[i] = prev.slot[i];
      else if (p < 65)           r.slot[i] = CODE_W'($urandom_range(KEY_TABLE_SIZE-1, 4));
      else if (p < 80)           r.slot[i] = '0;
      else if (p < 90 && i > 0)  r.slot[i] = r.slot[$urandom_range(i-1)];
      else                       r.slot[i] = CODE_W'($urandom_range(255));
    end
    return r;
  endfunction

  // offer one report word, wait for the handshake, then maybe idle a while
  task automatic offer(report_word_t r);
    int unsigned gap;
    rpt_if.valid         <= 1'b1;
    rpt_if.report_type   <= r.kind;
    rpt_if.modifier_bits <= r.mods;
    rpt_if.key_slot_0    <= r.slot[0];
    rpt_if.key_slot_1    <= r.slot[1];
    rpt_if.key_slot_2    <= r.slot[2];
    rpt_if.key_slot_3    <= r.slot[3];
    rpt_if.key_slot_4    <= r.slot[4];
    rpt_if.key_slot_5    <= r.slot[5];
    do @(posedge clk); while (!rpt_if.ready);
    sb.note_report(r);
    gap = no_idle ? 0 : sender_gap();
    if (gap > 0) begin
      rpt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: checks every taken word, random ready gaps, one long hold-off
  // --------------------------------------------------------------------------
  initial begin
    int unsigned gap_left;
    int unsigned hold_left;
    int unsigned hold_seen;
    evt_t        got;
    evt_if.ready = 1'b0;
    gap_left  = 0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (evt_if.valid === 1'b1 && evt_if.ready === 1'b1) begin
        got.is_modifier = evt_if.is_modifier;
        got.key_code    = evt_if.key_code;
        got.is_press    = evt_if.is_press;
        got.last        = evt_if.last;
        sb.check_event(got);
      end
      if (rst_n !== 1'b1) begin
        evt_if.ready <= 1'b0;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD_CYCLES;
        evt_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        evt_if.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        evt_if.ready <= 1'b0;
      end else begin
        evt_if.ready <= 1'b1;
        if (!no_idle) gap_left = receiver_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender and end of run
  // --------------------------------------------------------------------------
  initial begin
    report_word_t directed [$];
    report_word_t prev;
    report_word_t r;
    int           rnd_keys;
    int           n;
    int           waited;

    rst_n                = 1'b0;
    rpt_if.valid         = 1'b0;
    rpt_if.report_type   = '0;
    rpt_if.modifier_bits = '0;
    rpt_if.key_slot_0    = '0;
    rpt_if.key_slot_1    = '0;
    rpt_if.key_slot_2    = '0;
    rpt_if.key_slot_3    = '0;
    rpt_if.key_slot_4    = '0;
    rpt_if.key_slot_5    = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // non-key types carry content but must not touch the state
    directed.push_back(mk(0, 8'hFF, 4, 5, 6, 7, 8, 9));
    directed.push_back(mk(1, 8'h0F, 82, 0, 0, 0, 0, 0));
    directed.push_back(mk(255, 8'hFF, 255, 255, 255, 255, 255, 255));
    directed.push_back(mk(2, 0, 0, 0, 0, 0, 0, 0));
    // every modifier pressed; edges of the tracked range plus untracked codes
    directed.push_back(mk(2, 8'hFF, 4, 82, 49, 0, 3, 83));
    directed.push_back(mk(2, 8'h00, 255, 128, 1, 2, 0, 0));
    // duplicates press once
    directed.push_back(mk(2, 8'h55, 10, 10, 10, 20, 20, 4));
    directed.push_back(mk(2, 8'hAA, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(3, 8'h00, 30, 31, 32, 0, 0, 0));
    directed.push_back(mk(2, 8'hAA, 5, 6, 7, 8, 9, 11));
    directed.push_back(mk(2, 8'hAA, 5, 6, 7, 8, 9, 11));
    directed.push_back(mk(2, 8'hAA, 11, 9, 7, 0, 0, 0));
    directed.push_back(mk(2, 8'h80, 48, 50, 81, 82, 49, 127));
    directed.push_back(mk(2, 8'h01, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(8'h82, 8'h7F, 12, 13, 14, 15, 16, 17));
    directed.push_back(mk(2, 8'h01, 4, 5, 6, 7, 8, 9));
    directed.push_back(mk(0, 8'h00, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(2, 8'hFE, 255, 254, 200, 84, 64, 32));
    directed.push_back(mk(2, 8'h00, 0, 0, 0, 0, 0, 82));
    directed.push_back(mk(2, 8'h00, 82, 82, 82, 82, 82, 82));
    directed.push_back(mk(2, 8'h00, 0, 0, 0, 0, 0, 0));
    foreach (directed[i]) offer(directed[i]);

    prev     = mk(2, 0, 0, 0, 0, 0, 0, 0);
    rnd_keys = 0;
    n        = 0;
    while (rnd_keys < RANDOM_KEY_REPORTS) begin
      if (n == 60) hold_req <= hold_req + 1;
      if (n == 150) no_idle <= 1'b1;
      if (n == 190) no_idle <= 1'b0;
      case ($urandom_range(19))
        0, 1, 2: begin
          // other report types with random content, type bits exercised
          r = mk($urandom_range(255), $urandom_range(255), $urandom_range(255),
                 $urandom_range(255), $urandom_range(255), $urandom_range(255),
                 $urandom_range(255), $urandom_range(255));
        end
        3, 4: begin
          r = mk(2, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                 $urandom_range(255), $urandom_range(255), $urandom_range(255),
                 $urandom_range(255));
        end
        default: r = next_key_report(prev);
      endcase
      offer(r);
      if (r.kind == KEY_REPORT) begin
        prev = r;
        rnd_keys++;
      end
      n++;
    end
    rpt_if.valid <= 1'b0;

    waited = 0;
    while (sb.pending() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() > 0) sb.report_mismatch("words never produced", 0, sb.pending());

    $display("Run covered %0d reports (%0d key reports) and %0d event words checked,",
             sb.reports_seen, sb.key_reports, sb.events_checked);
    $display("with random gaps on both sides and a %0d-cycle output hold-off.",
             LONG_HOLD_CYCLES);
    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_500_000;
    $display("Timeout with %0d words still expected", sb.pending());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/hidkbd_pkg.sv
hw/rtl/hidkbd_if.sv
hw/rtl/hidkbd_ctrl.sv
hw/rtl/hidkbd_dp.sv
hw/rtl/hid_keyboard_report_to_key_events_core.sv
tb/sv/hid_keyboard_report_to_key_events_core_tb.sv
